FILE: sv/u2dt_pkg.sv
package u2dt_pkg;

  // payload widths of the two channels
  localparam int VALUE_HALF_W = 64;
  localparam int DIGIT_CHAR_W = 6;

  // default byte width of the converted value
  localparam int U2DT_VALUE_BYTES = 16;

  // the value is walked from the top in chunks of this many bits
  localparam int CHUNK_W = 16;

  // a chunk step divides {remainder, chunk} (20 bits) by ten:
  // q = (x * RECIP_10) >> RECIP_SHIFT is exact for every x below 655360
  localparam int            STEP_W      = 20;
  localparam int            PROD_W      = 40;
  localparam int            RECIP_SHIFT = 23;
  localparam logic [19:0]   RECIP_10    = 20'd838861;

  localparam logic [5:0]    ASCII_ZERO  = 6'd48;
  localparam logic [5:0]    ASCII_NINE  = 6'd57;

  // decimal digits of the largest value that fits in the given byte count
  function automatic int u2dt_max_digits(input int nbytes);
    int d;
    case (nbytes)
      1:       d = 3;
      2:       d = 5;
      3:       d = 8;
      4:       d = 10;
      5:       d = 13;
      6:       d = 15;
      7:       d = 17;
      8:       d = 20;
      9:       d = 22;
      10:      d = 25;
      11:      d = 27;
      12:      d = 29;
      13:      d = 32;
      14:      d = 34;
      15:      d = 37;
      default: d = 39;
    endcase
    return d;
  endfunction

endpackage

FILE: sv/u2dt_if.sv
interface u2dt_in_if import u2dt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [VALUE_HALF_W-1:0] value_high;
  logic [VALUE_HALF_W-1:0] value_low;

  modport source (output valid, output value_high, output value_low, input ready);
  modport sink   (input valid, input value_high, input value_low, output ready);
endinterface

interface u2dt_out_if import u2dt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [DIGIT_CHAR_W-1:0] digit_char;
  logic                    last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

FILE: sv/u128_to_decimal_text.sv
// Unsigned binary to decimal text converter. Each input transaction carries a
// 128-bit value as two 64-bit halves; only the low 8*VALUE_BYTES bits are used.
// The block answers with one output transaction per decimal digit, as ASCII,
// most significant digit first, no leading zeros, with last set on the final
// digit; zero gives the single digit '0'. One shared divide-by-ten step works
// on 16 bits of the value per cycle, so each digit takes a full pass over the
// ceil(VALUE_BYTES/2) chunks (8 for the full 128 bits), and output stalls
// hold the block while it sends the digits. Digits are collected on a small
// stack and popped out in reverse order. in_chan.ready is high only while no
// conversion is in flight; the final digit may still wait in the output
// register when the next value is taken.
module u128_to_decimal_text import u2dt_pkg::*; #(
  parameter int VALUE_BYTES = U2DT_VALUE_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  u2dt_in_if.sink     in_chan,
  u2dt_out_if.source  out_chan
);

  // byte count held to its legal range
  localparam int VB     = (VALUE_BYTES > 16) ? 16 : ((VALUE_BYTES < 1) ? 1 : VALUE_BYTES);
  localparam int VW     = 8 * VB;
  // number of 16-bit chunks and padded working width
  localparam int NCHUNK = (VB + 1) / 2;
  localparam int PW     = CHUNK_W * NCHUNK;
  localparam int CKW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int MAXD   = u2dt_max_digits(VB);
  localparam int CNTW   = $clog2(MAXD + 1);
  localparam int FULL_W = 2 * VALUE_HALF_W;

  localparam logic [FULL_W-1:0] VMASK =
    (VW >= FULL_W) ? {FULL_W{1'b1}} : ((FULL_W'(1) << VW) - FULL_W'(1));
  localparam logic [CKW-1:0]    CK_LAST = CKW'(NCHUNK - 1);
  localparam logic [CNTW-1:0]   CNT_ONE = CNTW'(1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [PW-1:0]           val_r, val_nxt;      // working value, shifted up a chunk per cycle while dividing
  logic [3:0]              rem_r, rem_nxt;      // running remainder within a pass
  logic [CKW-1:0]          ck_r, ck_nxt;        // chunk index within a pass
  logic                    nz_r, nz_nxt;        // any quotient chunk nonzero so far
  logic [3:0]              dig_r [MAXD];        // digit stack, top at index 0
  logic [3:0]              dig_nxt [MAXD];
  logic [CNTW-1:0]         cnt_r, cnt_nxt;      // digits on the stack
  logic                    out_valid_r, out_valid_nxt;
  logic [DIGIT_CHAR_W-1:0] out_digit_r, out_digit_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [FULL_W-1:0]       in_full;
  logic [STEP_W-1:0]       cur;
  logic [PROD_W-1:0]       prod;
  logic [CHUNK_W-1:0]      q;
  logic [3:0]              tenq_lo;
  logic [3:0]              rem_new;
  logic                    in_fire;
  logic                    out_load;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign in_full       = {in_chan.value_high, in_chan.value_low} & VMASK;

  // shared divide-by-ten step on {remainder, top chunk}
  assign cur     = {rem_r, val_r[PW-1 -: CHUNK_W]};
  assign prod    = PROD_W'(cur) * PROD_W'(RECIP_10);
  assign q       = prod[RECIP_SHIFT +: CHUNK_W];
  // low nibble of 10*q, enough since the remainder stays below ten
  assign tenq_lo = {q[0], 3'b000} + {q[2:0], 1'b0};
  assign rem_new = cur[3:0] - tenq_lo;

  // output register can take a new digit when empty or being drained
  assign out_load = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    rem_nxt       = rem_r;
    ck_nxt        = ck_r;
    nz_nxt        = nz_r;
    cnt_nxt       = cnt_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_chan.ready ? 1'b0 : out_valid_r;
    out_digit_nxt = out_digit_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt   = in_full[PW-1:0];
          rem_nxt   = '0;
          ck_nxt    = '0;
          nz_nxt    = 1'b0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // quotient chunk replaces the chunk just consumed, at the bottom
        val_nxt = (val_r << CHUNK_W) | PW'(q);
        if (ck_r == CK_LAST) begin
          // end of a pass: remainder is the next digit
          for (int i = 1; i < MAXD; i++) begin
            dig_nxt[i] = dig_r[i-1];
          end
          dig_nxt[0] = rem_new;
          cnt_nxt    = cnt_r + CNT_ONE;
          rem_nxt    = '0;
          ck_nxt     = '0;
          nz_nxt     = 1'b0;
          if (!(nz_r || (q != '0))) begin
            state_nxt = S_EMIT;
          end
        end else begin
          rem_nxt = rem_new;
          ck_nxt  = ck_r + CKW'(1);
          nz_nxt  = nz_r || (q != '0);
        end
      end
      S_EMIT: begin
        if (out_load) begin
          // most significant digit sits on top of the stack
          out_valid_nxt = 1'b1;
          out_digit_nxt = ASCII_ZERO + DIGIT_CHAR_W'(dig_r[0]);
          out_last_nxt  = (cnt_r == CNT_ONE);
          for (int i = 0; i < MAXD - 1; i++) begin
            dig_nxt[i] = dig_r[i+1];
          end
          dig_nxt[MAXD-1] = '0;
          cnt_nxt         = cnt_r - CNT_ONE;
          if (cnt_r == CNT_ONE) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ck_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ck_r        <= ck_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    rem_r       <= rem_nxt;
    nz_r        <= nz_nxt;
    dig_r       <= dig_nxt;
    out_digit_r <= out_digit_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.digit_char = out_digit_r;
  assign out_chan.last       = out_last_r;

`ifndef SYNTHESIS
  // the stack never holds more digits than the value width allows
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(MAXD))
    else $error("digit stack overflow");

  // while digits are being sent the stack is never empty
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (cnt_r != '0))
    else $error("emitting from an empty digit stack");

  // an accepted value starts a fresh conversion
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_DIV) && (cnt_r == '0) && (ck_r == '0))
    else $error("conversion did not start cleanly");

  // only ascii digits leave the block
  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_digit_r >= ASCII_ZERO) && (out_digit_r <= ASCII_NINE))
    else $error("output character is not a decimal digit");
`endif

endmodule

FILE: test/u128_to_decimal_text_tb.sv
`timescale 1ns / 100ps

module u128_to_decimal_text_tb;
  import u2dt_pkg::*;

  localparam int VALUE_BYTES = U2DT_VALUE_BYTES;
  // settle time after the last digit, about one full 39 digit conversion
  localparam int SETTLE_CYCLES = 400;
  // receiver hold-off used to back the block up into its input
  localparam int LONG_STALL_CYCLES = 600;

  // one ASCII digit as it leaves the block
  typedef struct packed {
    logic [DIGIT_CHAR_W-1:0] digit_char;
    logic                    last;
  } text_char_t;

  logic clk;
  logic rst_n;

  u2dt_in_if  in_chan ();
  u2dt_out_if out_chan ();

  u128_to_decimal_text #(.VALUE_BYTES(VALUE_BYTES)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // digits still owed by the block, oldest first
  text_char_t digits_due[$];
  int         mismatches;

  // idling controls, written at rising edges and read at falling edges
  bit tx_throttle;
  bit rx_throttle;
  bit stall_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------

  // gap length: mostly none, often a few cycles, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    else if (roll < 92) return $urandom_range(1, 3);
    else return $urandom_range(12, 40);
  endfunction

  function automatic logic [127:0] power_of_ten(input int exponent);
    logic [127:0] p;
    p = 128'd1;
    for (int i = 0; i < exponent; i++) p = p * 128'd10;
    return p;
  endfunction

  // decimal text of one value, most significant digit first, appended to
  // the expected digits; only the low 8*VALUE_BYTES bits take part
  task automatic queue_decimal_text(input logic [63:0] hi, input logic [63:0] lo);
    logic [127:0] v;
    logic [127:0] keep;
    logic [3:0]   rem;
    text_char_t   text[$];
    text_char_t   c;
    keep = (VALUE_BYTES >= 16) ? {128{1'b1}} :
           (VALUE_BYTES < 1)   ? 128'hff : ((128'd1 << (8 * VALUE_BYTES)) - 1);
    v = {hi, lo} & keep;
    if (v == 0) begin
      c.digit_char = ASCII_ZERO;
      c.last = 1'b0;
      text.push_front(c);
    end
    while (v != 0) begin
      rem = 4'(v % 128'd10);
      v = v / 128'd10;
      c.digit_char = ASCII_ZERO + DIGIT_CHAR_W'(rem);
      c.last = 1'b0;
      text.push_front(c);
    end
    // least significant digit closes the number
    text[text.size() - 1].last = 1'b1;
    foreach (text[i]) digits_due.push_back(text[i]);
  endtask

  // offer one value and hold it until the block takes it; entered and left
  // at a falling edge, valid stays high when no gap follows
  task automatic send_value(input logic [63:0] hi, input logic [63:0] lo);
    int gap;
    gap = tx_throttle ? pick_gap() : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.value_high <= hi;
    in_chan.value_low  <= lo;
    do @(posedge clk); while (!in_chan.ready);
    // transaction taken at this edge
    queue_decimal_text(hi, lo);
    @(negedge clk);
  endtask

  task automatic send_wide(input logic [127:0] v);
    send_value(v[127:64], v[63:0]);
  endtask

  // random value with a spread of digit counts, so short and long
  // conversions both show up
  task automatic send_random_value();
    logic [127:0] v;
    int           roll;
    int           nbits;
    roll = $urandom_range(99);
    v = {$urandom, $urandom, $urandom, $urandom};
    if (roll < 35) begin
      // full width, every bit free
    end else if (roll < 80) begin
      nbits = $urandom_range(1, 128);
      if (nbits < 128) v = v & ((128'd1 << nbits) - 1);
      v[nbits - 1] = 1'b1;
    end else if (roll < 90) begin
      // around a power of ten, where the digit count changes
      v = power_of_ten($urandom_range(0, 38)) + 128'($urandom_range(0, 2)) - 128'd1;
    end else begin
      v = 128'($urandom_range(0, 999));
    end
    send_wide(v);
  endtask

  // mode changes happen at a rising edge so the falling edge driver
  // never races them
  task automatic set_throttle(input bit tx, input bit rx);
    @(posedge clk);
    tx_throttle = tx;
    rx_throttle = rx;
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input text_char_t want,
                                 input text_char_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected char %0d last %0b, got char %0d last %0b",
               $realtime, what, want.digit_char, want.last, got.digit_char, got.last);
  endtask

  // --------------------------------------------------------------------------
  // receiver: random ready, plus a long counted hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int rx_gap;
    int stall_left;
    rx_gap = 0;
    stall_left = 0;
    out_chan.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        stall_left = LONG_STALL_CYCLES;
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else if (!rx_throttle) begin
        out_chan.ready <= 1'b1;
      end else if (rx_gap > 0) begin
        out_chan.ready <= 1'b0;
        rx_gap--;
      end else begin
        out_chan.ready <= 1'b1;
        if ($urandom_range(3) == 0) rx_gap = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // result check, one digit per output transaction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_digits
    text_char_t got;
    text_char_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.digit_char = out_chan.digit_char;
      got.last = out_chan.last;
      if (digits_due.size() == 0) begin
        want = '0;
        report_mismatch("digit with nothing expected", want, got);
      end else begin
        want = digits_due.pop_front();
        if (got.digit_char !== want.digit_char || got.last !== want.last)
          report_mismatch("digit mismatch", want, got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // zero, single digits, digit count boundaries and the widest values
  task automatic test_edge_values();
    set_throttle(1'b1, 1'b1);
    send_wide(128'd0);
    send_wide(128'd1);
    send_wide(128'd9);
    send_wide(128'd10);
    send_wide(128'd99);
    send_wide(128'd100);
    send_wide(128'd1234567890);
    send_value(64'd0, {64{1'b1}});
    send_value(64'd1, 64'd0);
    send_value({64{1'b1}}, 64'd0);
    send_value({64{1'b1}}, {64{1'b1}});
    send_wide(power_of_ten(19) - 128'd1);
    send_wide(power_of_ten(19));
    send_wide(power_of_ten(20));
    send_wide(power_of_ten(38) - 128'd1);
    send_wide(power_of_ten(38));
    send_wide({1'b1, 127'd0});
    send_wide({1'b1, 126'd0, 1'b1});
    send_value(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_value(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    // back to back zeros, the shortest possible answers in a row
    send_wide(128'd0);
    send_wide(128'd0);
  endtask

  // no idling on either side
  task automatic test_streaming();
    set_throttle(1'b0, 1'b0);
    repeat (40) send_random_value();
  endtask

  // receiver holds off long enough that the block stops taking values
  // while the sender keeps offering them
  task automatic test_output_stall();
    set_throttle(1'b0, 1'b0);
    @(posedge clk);
    stall_request = 1'b1;
    @(negedge clk);
    repeat (20) send_random_value();
  endtask

  // bulk random, throttling on both sides is redrawn every 30 values
  task automatic test_random_values();
    for (int i = 0; i < 190; i++) begin
      if (i % 30 == 0) set_throttle($urandom_range(3) != 0, $urandom_range(3) != 0);
      send_random_value();
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    mismatches = 0;
    tx_throttle = 1'b0;
    rx_throttle = 1'b0;
    stall_request = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.value_high = '0;
    in_chan.value_low = '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_edge_values();
    test_streaming();
    test_output_stall();
    test_random_values();

    // drain: nothing more to send, wait for every owed digit
    in_chan.valid <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
    // anything extra would show up within one more conversion time
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[u128_to_decimal_text] OK");
    end else begin
      $display("[u128_to_decimal_text] ERROR");
    end
    $finish;
  end

  // hard limit, several times the slowest correct run
  initial begin
    #(64'd30_000_000);
    $display("[u128_to_decimal_text] ERROR");
    $finish;
  end

endmodule
